// ===== sv/tmhq_pkg.sv =====
// Shared constants and codes for the ternary min-heap priority queue.
`default_nettype none
package tmhq_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int ARITY_DEF    = 3;

	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 32;
	localparam int PAIR_W   = KEY_W + VALUE_W;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_POP    = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage
`default_nettype wire

// ===== sv/tmhq_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module tmhq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/ternary_min_heap_queue_unit.sv =====
// Top level of the d-ary min-heap priority queue of key/value pairs.
`default_nettype none
// Each input word is an insert or a pop; each produces exactly one result word carrying the
// status, the popped pair, the entry count, the empty flag and the current top pair. The
// heap lives in one RAM with a single write and a single registered read port, and that read
// port sets the speed. An insert reads and compares one parent at a time, moving each larger
// parent down, and then writes the new pair. A pop reads the last entry and sifts it down,
// reading every child present at each node it visits. A failed operation or the pop of the
// only entry goes straight to the result. A stalled output register holds a finished result
// back until it drains. One operation is worked on at a time; the next word is taken as soon
// as the result is in the output register, even while that result is still stalled. The RAM
// needs no clearing after reset.
module ternary_min_heap_queue_unit #(
	parameter int CAPACITY = tmhq_pkg::CAPACITY_DEF,
	parameter int ARITY    = tmhq_pkg::ARITY_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 func,
	input  wire logic signed [tmhq_pkg::KEY_W-1:0]    key,
	input  wire logic signed [tmhq_pkg::VALUE_W-1:0]  value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic             [tmhq_pkg::STATUS_W-1:0] status,
	output logic signed      [tmhq_pkg::KEY_W-1:0]    popped_key,
	output logic signed      [tmhq_pkg::VALUE_W-1:0]  popped_value,
	output logic             [tmhq_pkg::COUNT_W-1:0]  entry_count,
	output logic                                      is_empty,
	output logic signed      [tmhq_pkg::KEY_W-1:0]    top_key,
	output logic signed      [tmhq_pkg::VALUE_W-1:0]  top_value
);

	localparam int KW_ = tmhq_pkg::KEY_W;
	localparam int VW_ = tmhq_pkg::VALUE_W;
	localparam int PW  = tmhq_pkg::PAIR_W;
	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int IW  = $clog2(CAPACITY * ARITY + ARITY + 1);
	localparam int KCW = $clog2(ARITY + 1);

	// Parent index (x-1)/ARITY as an exact reciprocal multiply for all AW-bit x.
	localparam int PSH = AW + $clog2(ARITY);
	localparam int MW  = PSH + 1;
	localparam logic [MW-1:0] PMUL = MW'(((2 ** PSH) + ARITY - 1) / ARITY);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_UP_RD   = 3'd1;
	localparam logic [2:0] S_UP_CMP  = 3'd2;
	localparam logic [2:0] S_UP_FIN  = 3'd3;
	localparam logic [2:0] S_POP_RD  = 3'd4;
	localparam logic [2:0] S_POP_LD  = 3'd5;
	localparam logic [2:0] S_DN_SCAN = 3'd6;
	localparam logic [2:0] S_RESP    = 3'd7;

	function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] x);
		logic [AW-1:0]    xm;
		logic [AW+MW-1:0] prod;
		xm   = x - 1'b1;
		prod = {{MW{1'b0}}, xm} * {{AW{1'b0}}, PMUL};
		return prod[PSH +: AW];
	endfunction

	logic [2:0]    st_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] x_q;
	logic [PW-1:0] top_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] par_q;
	logic [IW-1:0] base_q;
	logic [KCW-1:0] k_q;
	logic          pend_s1;
	logic [AW-1:0] pidx_s1;
	logic [PW-1:0] best_q;
	logic [AW-1:0] best_idx_q;
	logic          best_x_q;

	logic [tmhq_pkg::STATUS_W-1:0] stat_q;
	logic [PW-1:0]                 popped_q;

	logic                          out_valid_q;
	logic [tmhq_pkg::STATUS_W-1:0] out_status_q;
	logic [PW-1:0]                 out_popped_q;
	logic [CW-1:0]                 out_count_q;
	logic [PW-1:0]                 out_top_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [PW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [PW-1:0] ram_rdata;

	logic          in_acc;
	logic          out_free;
	logic [IW-1:0] child_idx;
	logic          can_issue;
	logic          child_lt;
	logic [PW-1:0] best_next;
	logic [AW-1:0] best_idx_next;
	logic          best_x_next;
	logic          x_lt_par;

	tmhq_ram #(
		.WIDTH (PW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign in_stall = (st_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign child_idx = base_q + IW'(k_q);
	assign can_issue = (k_q < KCW'(ARITY)) && (child_idx < IW'(count_q));
	assign child_lt  = $signed(ram_rdata[PW-1 -: KW_]) < $signed(best_q[PW-1 -: KW_]);
	assign x_lt_par  = $signed(x_q[PW-1 -: KW_]) < $signed(ram_rdata[PW-1 -: KW_]);

	// A child replaces the best only if strictly smaller, so equal keys never displace the current best.
	always_comb begin
		best_next     = best_q;
		best_idx_next = best_idx_q;
		best_x_next   = best_x_q;
		if (pend_s1 && child_lt) begin
			best_next     = ram_rdata;
			best_idx_next = pidx_s1;
			best_x_next   = 1'b0;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = x_q;
		ram_re    = 1'b0;
		ram_raddr = par_q;
		case (st_q)
			S_UP_RD: begin
				ram_re = 1'b1;
			end
			S_UP_CMP: begin
				if (x_lt_par) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
				end
			end
			S_UP_FIN: begin
				ram_we = 1'b1;
			end
			S_POP_RD: begin
				ram_re    = 1'b1;
				ram_raddr = count_q[AW-1:0];
			end
			S_DN_SCAN: begin
				if (can_issue) begin
					ram_re    = 1'b1;
					ram_raddr = child_idx[AW-1:0];
				end else begin
					ram_we    = 1'b1;
					ram_wdata = best_x_next ? x_q : best_next;
				end
			end
			default: begin
			end
		endcase
	end

	// Mirror of the root entry, kept current on every write to the first slot.
	always_ff @(posedge clk) begin
		if (ram_we && ram_waddr == '0) begin
			top_q <= ram_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			pend_s1     <= 1'b0;
			best_x_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						x_q      <= {key, value};
						cur_q    <= count_q[AW-1:0];
						if (func == tmhq_pkg::FUNC_INSERT) begin
							popped_q <= '0;
							if (count_q >= CW'(CAPACITY)) begin
								stat_q <= tmhq_pkg::STAT_FULL;
								st_q   <= S_RESP;
							end else begin
								stat_q  <= tmhq_pkg::STAT_OK;
								count_q <= CW'(count_q + 1'b1);
								if (count_q == '0) begin
									st_q <= S_UP_FIN;
								end else begin
									par_q <= parent_of(count_q[AW-1:0]);
									st_q  <= S_UP_RD;
								end
							end
						end else begin
							if (count_q == '0) begin
								stat_q   <= tmhq_pkg::STAT_EMPTY;
								popped_q <= '0;
								st_q     <= S_RESP;
							end else begin
								stat_q   <= tmhq_pkg::STAT_OK;
								popped_q <= top_q;
								count_q  <= CW'(count_q - 1'b1);
								st_q     <= (count_q == CW'(1)) ? S_RESP : S_POP_RD;
							end
						end
					end
				end
				S_UP_RD: begin
					st_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					if (x_lt_par) begin
						cur_q <= par_q;
						if (par_q == '0) begin
							st_q <= S_UP_FIN;
						end else begin
							par_q <= parent_of(par_q);
							st_q  <= S_UP_RD;
						end
					end else begin
						st_q <= S_UP_FIN;
					end
				end
				S_UP_FIN: begin
					st_q <= S_RESP;
				end
				S_POP_RD: begin
					st_q <= S_POP_LD;
				end
				S_POP_LD: begin
					x_q        <= ram_rdata;
					best_q     <= ram_rdata;
					best_x_q   <= 1'b1;
					cur_q      <= '0;
					base_q     <= IW'(1);
					k_q        <= '0;
					pend_s1    <= 1'b0;
					st_q       <= S_DN_SCAN;
				end
				S_DN_SCAN: begin
					if (can_issue) begin
						best_q     <= best_next;
						best_idx_q <= best_idx_next;
						best_x_q   <= best_x_next;
						k_q        <= KCW'(k_q + 1'b1);
						pend_s1    <= 1'b1;
						pidx_s1    <= child_idx[AW-1:0];
					end else if (best_x_next) begin
						pend_s1 <= 1'b0;
						st_q    <= S_RESP;
					end else begin
						// The smaller child moved up; continue one level down.
						cur_q    <= best_idx_next;
						base_q   <= IW'(best_idx_next) * IW'(ARITY) + IW'(1);
						k_q      <= '0;
						pend_s1  <= 1'b0;
						best_q   <= x_q;
						best_x_q <= 1'b1;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_status_q <= stat_q;
						out_popped_q <= popped_q;
						out_count_q  <= count_q;
						out_top_q    <= (count_q == '0) ? '0 : top_q;
						st_q         <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign popped_key   = out_popped_q[PW-1 -: KW_];
	assign popped_value = out_popped_q[VW_-1:0];
	assign entry_count  = tmhq_pkg::COUNT_W'(out_count_q);
	assign is_empty     = (out_count_q == '0);
	assign top_key      = out_top_q[PW-1 -: KW_];
	assign top_value    = out_top_q[VW_-1:0];

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) < count_q))
		else $error("heap write beyond the stored entries");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && func == tmhq_pkg::FUNC_POP && count_q != '0)
		|=> (count_q == CW'($past(count_q) - 1'b1)))
		else $error("successful pop did not remove exactly one entry");
`endif

endmodule
`default_nettype wire
